// ----- sv/deq_pkg.sv -----
// Shared types and constants for the double-ended queue.
package deq_pkg;

	// Default ring depth and field widths
	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int REQ_W     = 3;

	// Request codes carried in the input tuser field
	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_REVERSE    = 3'd4,
		REQ_CLEAR      = 3'd5
	} req_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic upd;   // apply the accepted request to the queue state
		logic rd;    // read both ends of the ring
	} cmd_t;

endpackage

// ----- sv/deq_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
module deq_ram #(
	parameter int WIDTH = deq_pkg::DATA_W,
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Register both read ports
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

// ----- sv/deq_ctrl.sv -----
// Controller state machine: sequences accept, ring read and result transaction.
module deq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output deq_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Drive handshakes and datapath commands
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign cmd.upd  = (state_q == ST_IDLE) && s_tvalid;
	assign cmd.rd   = (state_q == ST_READ);

	// Never take a request while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while result pending");

	// An accepted transaction is followed by the ring read
	a_acc_read: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_READ))
		else $error("ring read did not follow accept");

	// The read always leads straight to a valid result
	a_read_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> m_tvalid)
		else $error("result not presented after read");

endmodule

// ----- sv/deq_dpath.sv -----
// Datapath: ring pointers, count, direction flag and the ring RAM.
module deq_dpath #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  deq_pkg::cmd_t                    cmd,
	input  logic [deq_pkg::REQ_W-1:0]        req_type,
	input  logic signed [deq_pkg::DATA_W-1:0] push_value,
	output logic signed [deq_pkg::DATA_W-1:0] front_value,
	output logic signed [deq_pkg::DATA_W-1:0] back_value,
	output logic [$clog2(DEPTH+1)-1:0]       entry_count,
	output logic                             is_empty,
	output logic                             push_dropped
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [IDX_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic             rev_q;
	logic             drop_q;

	logic [IDX_W-1:0] head_d, tail_d;
	logic [CNT_W-1:0] count_d;
	logic             rev_d;
	logic             drop_d;
	logic             we_c;
	logic [IDX_W-1:0] waddr_c;
	logic             low_end_c;
	logic [IDX_W-1:0] head_prev_c, head_next_c, tail_prev_c, tail_next_c;
	logic [deq_pkg::DATA_W-1:0] rd_lo, rd_hi;
	deq_pkg::req_t    req_c;

	// Ring neighbors of both ends
	assign head_prev_c = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign head_next_c = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_prev_c = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
	assign tail_next_c = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;

	assign req_c = deq_pkg::req_t'(req_type);

	// Work out the state after the request
	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		rev_d     = rev_q;
		drop_d    = 1'b0;
		we_c      = 1'b0;
		waddr_c   = head_q;
		low_end_c = 1'b0;
		case (req_c)
			deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
				// front is the low end unless reversed
				low_end_c = (req_c == deq_pkg::REQ_PUSH_FRONT) ? !rev_q : rev_q;
				if (count_q == FULL_CNT) begin
					drop_d = 1'b1;
				end else begin
					we_c    = 1'b1;
					count_d = count_q + 1'b1;
					if (count_q == '0) begin
						tail_d  = head_q;
						waddr_c = head_q;
					end else if (low_end_c) begin
						head_d  = head_prev_c;
						waddr_c = head_prev_c;
					end else begin
						tail_d  = tail_next_c;
						waddr_c = tail_next_c;
					end
				end
			end
			deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
				low_end_c = (req_c == deq_pkg::REQ_POP_FRONT) ? !rev_q : rev_q;
				if (count_q != '0) begin
					count_d = count_q - 1'b1;
					if (count_q == CNT_W'(1)) begin
						tail_d = head_q;
					end else if (low_end_c) begin
						head_d = head_next_c;
					end else begin
						tail_d = tail_prev_c;
					end
				end
			end
			deq_pkg::REQ_REVERSE: begin
				rev_d = !rev_q;
			end
			deq_pkg::REQ_CLEAR: begin
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
				rev_d   = 1'b0;
			end
			default: begin
				// unused codes leave the state alone
			end
		endcase
	end

	// Advance the queue state on an accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
			drop_q  <= 1'b0;
		end else if (cmd.upd) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			rev_q   <= rev_d;
			drop_q  <= drop_d;
		end
	end

	// Ring store
	deq_ram #(
		.WIDTH (deq_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (cmd.upd && we_c),
		.wr_addr   (waddr_c),
		.wr_data   (push_value),
		.rd_en     (cmd.rd),
		.rd_addr_a (head_q),
		.rd_addr_b (tail_q),
		.rd_data_a (rd_lo),
		.rd_data_b (rd_hi)
	);

	// Build the result fields
	assign is_empty     = (count_q == '0);
	assign entry_count  = count_q;
	assign push_dropped = drop_q;
	assign front_value  = is_empty ? '1 : (rev_q ? rd_hi : rd_lo);
	assign back_value   = is_empty ? '1 : (rev_q ? rd_lo : rd_hi);

	// Count stays within the ring
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count exceeds depth");

	// Empty queue has both ends on one slot
	a_empty_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty queue with split pointers");

	// A dropped push leaves a full, unchanged count
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |=> (!drop_q || ((count_q == FULL_CNT) && $stable(count_q))))
		else $error("push dropped without full store");

endmodule

// ----- sv/double_ended_queue_top.sv -----
// Top level of the double-ended queue: stream ports, controller and datapath.
//
//  channel  direction  tdata                         tuser
//  s_*      in         push_value[31:0]              req_type[2:0]
//  m_*      out        front, back, count, flags     -
//
// Each transaction steps through accept and update, ring read and result:
// the ring RAM write is followed by its registered read. A stalled result
// holds until m_tready; no new request is taken meanwhile. arst_n clears
// pointers, count and the direction flag; the ring contents are not cleared.
module double_ended_queue_top #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [deq_pkg::DATA_W-1:0]           s_tdata,   // [31:0] push_value
	input  logic [deq_pkg::REQ_W-1:0]            s_tuser,   // [2:0] req_type
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// front_value, back_value, entry_count, is_empty, push_dropped, zero pad
	output logic [((2*deq_pkg::DATA_W + $clog2(DEPTH+1) + 2 + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int CNT_W    = $clog2(DEPTH+1);
	localparam int OUT_BITS = 2*deq_pkg::DATA_W + CNT_W + 2;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	deq_pkg::cmd_t                     cmd;
	logic signed [deq_pkg::DATA_W-1:0] front_value, back_value;
	logic [CNT_W-1:0]                  entry_count;
	logic                              is_empty, push_dropped;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	deq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_type     (s_tuser),
		.push_value   (s_tdata),
		.front_value  (front_value),
		.back_value   (back_value),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.push_dropped (push_dropped)
	);

	// Pack the result, first field lowest
	logic [OUT_BITS-1:0] result_c;
	assign result_c = {push_dropped, is_empty, entry_count, back_value, front_value};
	assign m_tdata  = OUT_W'(result_c);

endmodule

// ----- tb/double_ended_queue_top_tb.sv -----
// Self-checking testbench for the double-ended queue stream block.
module double_ended_queue_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = deq_pkg::DEPTH_DEF;
	localparam int DATA_W = deq_pkg::DATA_W;
	localparam int REQ_W = deq_pkg::REQ_W;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OUT_W = ((2 * DATA_W + CNT_W + 2 + 7) / 8) * 8;
	localparam int REQUEST_TOTAL = 1350;
	localparam int LONG_HOLD_AT = 300;
	localparam int LONG_HOLD_CYCLES = 400;

	// Codes outside the enum that the block must ignore
	localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

	typedef struct {
		logic [DATA_W-1:0] front_value;
		logic [DATA_W-1:0] back_value;
		logic [CNT_W-1:0]  entry_count;
		logic              is_empty;
		logic              push_dropped;
	} deque_status_t;

	// Shadow deque: tracks the ring and predicts the status after each request
	class deque_shadow;
		logic [DATA_W-1:0] ring [DEPTH];
		int head;
		int tail;
		int entries;
		bit reversed;
		int fails;
		deque_status_t expected_status [$];

		function new();
			head = 0;
			tail = 0;
			entries = 0;
			reversed = 0;
			fails = 0;
		endfunction

		task flag(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
			fails++;
			$display("%0t ns: deque %0s wrong, got %h want %h", $time, field, got, want);
		endtask

		// Apply one accepted request and queue the status it should produce
		function void apply_request(logic [REQ_W-1:0] code, logic [DATA_W-1:0] value);
			bit front_low;
			bit low_end;
			bit dropped;
			deque_status_t want;
			front_low = !reversed;
			dropped = 0;
			case (code)
				deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
					if (entries >= DEPTH) begin
						dropped = 1;
					end else begin
						low_end = (code == deq_pkg::REQ_PUSH_FRONT) ? front_low : !front_low;
						if (entries == 0)
							tail = head;
						else if (low_end)
							head = (head == 0) ? DEPTH - 1 : head - 1;
						else
							tail = (tail + 1 >= DEPTH) ? 0 : tail + 1;
						ring[low_end ? head : tail] = value;
						entries++;
					end
				end
				deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
					if (entries != 0) begin
						low_end = (code == deq_pkg::REQ_POP_FRONT) ? front_low : !front_low;
						if (entries > 1) begin
							if (low_end)
								head = (head + 1 >= DEPTH) ? 0 : head + 1;
							else
								tail = (tail == 0) ? DEPTH - 1 : tail - 1;
						end else begin
							tail = head;
						end
						entries--;
					end
				end
				deq_pkg::REQ_REVERSE: reversed = !reversed;
				deq_pkg::REQ_CLEAR: begin
					entries = 0;
					head = 0;
					tail = 0;
					reversed = 0;
				end
				default: ;
			endcase
			want.front_value = '1;
			want.back_value = '1;
			if (entries != 0) begin
				want.front_value = reversed ? ring[tail] : ring[head];
				want.back_value = reversed ? ring[head] : ring[tail];
			end
			want.entry_count = CNT_W'(entries);
			want.is_empty = (entries == 0);
			want.push_dropped = dropped;
			expected_status.insert(expected_status.size(), want);
		endfunction

		// Compare one accepted result with the oldest expected status
		task compare_status(logic [OUT_W-1:0] word);
			deque_status_t want;
			if (expected_status.size() == 0) begin
				flag("result with no request", word[DATA_W-1:0], '0);
				return;
			end
			want = expected_status[0];
			expected_status.delete(0);
			if (word[DATA_W-1:0] !== want.front_value)
				flag("front_value", word[DATA_W-1:0], want.front_value);
			if (word[2*DATA_W-1:DATA_W] !== want.back_value)
				flag("back_value", word[2*DATA_W-1:DATA_W], want.back_value);
			if (word[2*DATA_W +: CNT_W] !== want.entry_count)
				flag("entry_count", DATA_W'(word[2*DATA_W +: CNT_W]), DATA_W'(want.entry_count));
			if (word[2*DATA_W+CNT_W] !== want.is_empty)
				flag("is_empty", DATA_W'(word[2*DATA_W+CNT_W]), DATA_W'(want.is_empty));
			if (word[2*DATA_W+CNT_W+1] !== want.push_dropped)
				flag("push_dropped", DATA_W'(word[2*DATA_W+CNT_W+1]), DATA_W'(want.push_dropped));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;   // [31:0] push_value
	logic [REQ_W-1:0]  s_tuser;   // [2:0] req_type
	logic              m_tvalid;
	logic              m_tready;
	// [31:0] front_value, [63:32] back_value, [68:64] entry_count,
	// [69] is_empty, [70] push_dropped, [71] zero pad
	logic [OUT_W-1:0]  m_tdata;

	deque_shadow shadow = new();
	int requests_sent = 0;
	int results_taken = 0;
	int src_mode = 0;

	double_ended_queue_top #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Idle length per transaction: none, short, or the full 0..14 range
	function automatic int idle_cycles(int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 3);
			default: return $urandom_range(0, 14);
		endcase
	endfunction

	// Push value, leaning on the signed extremes now and then
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [REQ_W-1:0] pick_pop();
		return $urandom_range(0, 1) ? deq_pkg::REQ_POP_FRONT : deq_pkg::REQ_POP_BACK;
	endfunction

	function automatic logic [REQ_W-1:0] pick_push();
		return $urandom_range(0, 1) ? deq_pkg::REQ_PUSH_FRONT : deq_pkg::REQ_PUSH_BACK;
	endfunction

	// Offer one request and hold it until it is accepted
	task automatic offer_request(logic [REQ_W-1:0] code, logic [DATA_W-1:0] value);
		int gap;
		gap = idle_cycles(src_mode);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= code;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		shadow.apply_request(code, value);
		if (code <= deq_pkg::REQ_CLEAR)
			requests_sent++;
		@(negedge clk);
	endtask

	// Hold the sender until every expected status has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (shadow.expected_status.size() != 0)
			@(negedge clk);
	endtask

	// Result side: random stalls plus one long hold-off
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = idle_cycles((results_taken / 64) % 3);
			if (results_taken == LONG_HOLD_AT)
				gap = LONG_HOLD_CYCLES;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			shadow.compare_status(m_tdata);
			results_taken++;
			@(negedge clk);
		end
	end

	// Request side: directed cases, then random phases
	initial begin
		int phase;
		int run_len;
		int pick;
		int r;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = deq_pkg::REQ_PUSH_FRONT;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty queue: pops, reverse and ignored codes leave it alone
		offer_request(deq_pkg::REQ_POP_FRONT, 32'h1234_5678);
		offer_request(deq_pkg::REQ_POP_BACK, 32'h8765_4321);
		offer_request(deq_pkg::REQ_REVERSE, '0);
		offer_request(REQ_RSVD6, 32'hFFFF_FFFF);
		offer_request(REQ_RSVD7, 32'h5555_AAAA);
		// Extremes at both ends, with and without reversal
		offer_request(deq_pkg::REQ_PUSH_FRONT, 32'h7FFF_FFFF);
		offer_request(deq_pkg::REQ_PUSH_BACK, 32'h8000_0000);
		offer_request(deq_pkg::REQ_REVERSE, '0);
		offer_request(deq_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF);
		offer_request(deq_pkg::REQ_PUSH_BACK, 32'h0000_0000);
		offer_request(deq_pkg::REQ_POP_FRONT, '0);
		offer_request(deq_pkg::REQ_POP_BACK, '0);
		// Fill the ring, then push into a full store at both ends
		repeat (DEPTH - 2) offer_request(pick_push(), $urandom);
		offer_request(deq_pkg::REQ_PUSH_FRONT, 32'hAAAA_5555);
		offer_request(deq_pkg::REQ_PUSH_BACK, 32'h5555_AAAA);
		offer_request(deq_pkg::REQ_CLEAR, '0);

		requests_sent = 0;
		phase = 0;
		while (requests_sent < REQUEST_TOTAL) begin
			src_mode = $urandom_range(0, 2);
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				// Mixed traffic with pushes and pops roughly balanced
				run_len = $urandom_range(30, 60);
				repeat (run_len) begin
					r = $urandom_range(0, 99);
					if (r < 24)
						offer_request(deq_pkg::REQ_PUSH_FRONT, pick_value());
					else if (r < 48)
						offer_request(deq_pkg::REQ_PUSH_BACK, pick_value());
					else if (r < 66)
						offer_request(deq_pkg::REQ_POP_FRONT, $urandom);
					else if (r < 84)
						offer_request(deq_pkg::REQ_POP_BACK, $urandom);
					else if (r < 95)
						offer_request(deq_pkg::REQ_REVERSE, $urandom);
					else if (r < 97)
						offer_request(deq_pkg::REQ_CLEAR, $urandom);
					else
						offer_request($urandom_range(0, 1) ? REQ_RSVD6 : REQ_RSVD7, $urandom);
				end
			end else if (pick < 9) begin
				// Fill past full, then drain past empty
				run_len = DEPTH - shadow.entries + $urandom_range(1, 3);
				repeat (run_len) offer_request(pick_push(), pick_value());
				if ($urandom_range(0, 1))
					offer_request(deq_pkg::REQ_REVERSE, $urandom);
				while (shadow.entries > 0) begin
					if ($urandom_range(0, 7) == 0)
						offer_request(deq_pkg::REQ_REVERSE, $urandom);
					else
						offer_request(pick_pop(), $urandom);
				end
				repeat ($urandom_range(1, 2)) offer_request(pick_pop(), $urandom);
			end else begin
				// Noise: any code, any value
				repeat (10) offer_request(REQ_W'($urandom_range(0, 7)), $urandom);
			end
			if (phase == 0 || $urandom_range(0, 4) == 0)
				wait_drained();
			phase++;
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (shadow.fails == 0)
			$display("double_ended_queue_top: match");
		else
			$display("double_ended_queue_top: mismatch");
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("double_ended_queue_top: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
sv/deq_pkg.sv
sv/deq_ram.sv
sv/deq_ctrl.sv
sv/deq_dpath.sv
sv/double_ended_queue_top.sv
tb/double_ended_queue_top_tb.sv
